// File: rtl/core/ple_pkg.sv
// ----------------------------------------------------------------------------
// ple_pkg
// types and constants shared by the positional list engine
// ----------------------------------------------------------------------------
package ple_pkg;

	localparam int CAPACITY_DEF = 16;
	localparam int MAX_RESULTS = 16;

	typedef enum logic [2:0] {
		ACT_INS_FRONT = 3'd0,
		ACT_INS_POS   = 3'd1,
		ACT_DEL_FRONT = 3'd2,
		ACT_DEL_TAIL  = 3'd3,
		ACT_DEL_POS   = 3'd4,
		ACT_READ      = 3'd5
	} action_t;

	typedef enum logic [1:0] {
		ST_OK    = 2'd0,
		ST_RANGE = 2'd1,
		ST_EMPTY = 2'd2,
		ST_FULL  = 2'd3
	} status_t;

	typedef enum logic [2:0] {
		S_IDLE,
		S_INS,
		S_DEL,
		S_READ,
		S_READ_WAIT
	} fsm_t;

	typedef struct packed {
		logic [2:0]         action;
		logic signed [31:0] value;
		logic [3:0]         position;
	} in_beat_t;

	typedef struct packed {
		logic [1:0]         status;
		logic signed [31:0] element;
		logic [4:0]         length;
		logic               last;
	} out_beat_t;

endpackage

// File: rtl/core/positional_list_engine_top.sv
// error status results are valid in the cycle after the input beat is taken
// insert at p shifts the entries from the tail down to p up by one, then writes the value; delete shifts down
// read-out: elements pass the memory read and the output register, then one per cycle while not stalled;
//   a stalled output makes the engine reread the waiting element
// one item at a time; the next beat is taken at the edge the last result leaves
// arst_n clears the count and control; the element store is not cleared
// ----------------------------------------------------------------------------
// positional_list_engine_top
// ordered list of signed words kept in one memory, shifted in place
// ----------------------------------------------------------------------------
module positional_list_engine_top import ple_pkg::*; #(
	parameter int CAPACITY = CAPACITY_DEF,
	localparam int AW = $clog2(CAPACITY),
	localparam int CW = $clog2(CAPACITY + 1)
) (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      in_valid,
	output logic      in_stall,
	input  in_beat_t  in_data,
	output logic      out_valid,
	input  logic      out_stall,
	output out_beat_t out_data
);

	localparam int PW = (CW > 4) ? CW : 4;

	fsm_t            state_q, state_d;
	logic [CW-1:0]   count_q, count_d;
	logic [CW-1:0]   idx_q, idx_d;
	logic [CW-1:0]   stop_q, stop_d;
	logic [31:0]     val_q, val_d;
	logic            ov_q, ov_d;
	out_beat_t       od_q, od_d;
	logic            we;
	logic [AW-1:0]   waddr, raddr;
	logic [31:0]     wdata, rdata;
	logic            rd_s1;
	logic [CW-1:0]   ridx_s1;
	logic [PW-1:0]   pos;
	logic [CW-1:0]   nread;
	logic            accept, out_free;

	ple_mem #(.CAPACITY(CAPACITY)) u_mem (
		.clk(clk), .we(we), .waddr(waddr), .wdata(wdata), .raddr(raddr), .rdata(rdata)
	);

	assign out_free = !ov_q || !out_stall;
	assign in_stall = !(state_q == S_IDLE && out_free);
	assign accept = in_valid && !in_stall;
	assign out_valid = ov_q;
	assign out_data = od_q;
	assign nread = (int'(count_q) > MAX_RESULTS) ? CW'(MAX_RESULTS) : count_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			count_q <= '0;
			ov_q <= 1'b0;
			rd_s1 <= 1'b0;
		end else begin
			state_q <= state_d;
			count_q <= count_d;
			ov_q <= ov_d;
			rd_s1 <= (state_q == S_DEL && idx_q < stop_q) ||
				(state_q == S_READ && idx_q < stop_q && !(rd_s1 && !out_free));
		end
	end

	always_ff @(posedge clk) begin
		idx_q <= idx_d;
		stop_q <= stop_d;
		val_q <= val_d;
		od_q <= od_d;
		ridx_s1 <= idx_q;
	end

	always_comb begin
		state_d = state_q;
		count_d = count_q;
		idx_d = idx_q;
		stop_d = stop_q;
		val_d = val_q;
		ov_d = ov_q && out_stall;
		od_d = od_q;
		we = 1'b0;
		waddr = idx_q[AW-1:0];
		wdata = val_q;
		raddr = idx_q[AW-1:0];
		pos = PW'(in_data.position);
		case (state_q)
			S_IDLE: begin
				if (accept) begin
					od_d = '{status: ST_OK, element: '0, length: 5'(count_q), last: 1'b1};
					case (in_data.action)
						ACT_INS_FRONT, ACT_INS_POS: begin
							if (in_data.action == ACT_INS_FRONT) pos = '0;
							if (pos > PW'(count_q)) begin
								od_d.status = ST_RANGE;
								ov_d = 1'b1;
							end else if (count_q >= CW'(CAPACITY)) begin
								od_d.status = ST_FULL;
								ov_d = 1'b1;
							end else begin
								// shift up from the tail, carry value down
								idx_d = count_q;
								stop_d = CW'(pos);
								val_d = in_data.value;
								state_d = S_INS;
							end
						end
						ACT_DEL_FRONT, ACT_DEL_TAIL, ACT_DEL_POS: begin
							if (in_data.action == ACT_DEL_FRONT) pos = '0;
							if (in_data.action == ACT_DEL_TAIL) pos = PW'(count_q) - 1'b1;
							if (count_q == '0) begin
								od_d.status = ST_EMPTY;
								ov_d = 1'b1;
							end else if (pos >= PW'(count_q)) begin
								od_d.status = ST_RANGE;
								ov_d = 1'b1;
							end else begin
								idx_d = CW'(pos + 1'b1);
								stop_d = count_q;
								state_d = S_DEL;
							end
						end
						ACT_READ: begin
							if (count_q == '0) begin
								od_d.status = ST_EMPTY;
								ov_d = 1'b1;
							end else begin
								idx_d = '0;
								stop_d = nread;
								state_d = S_READ;
							end
						end
						default: ;
					endcase
				end
			end
			S_INS: begin
				// read entry idx-1, next cycle write it to idx
				raddr = AW'(idx_q - 1'b1);
				if (idx_q == stop_q) begin
					we = 1'b1;
					count_d = count_q + 1'b1;
					od_d = '{status: ST_OK, element: '0, length: 5'(count_q + 1'b1), last: 1'b1};
					ov_d = 1'b1;
					state_d = S_IDLE;
				end else begin
					state_d = S_READ_WAIT;
					val_d = val_q;
				end
			end
			S_READ_WAIT: begin
				we = 1'b1;
				wdata = rdata;
				idx_d = idx_q - 1'b1;
				state_d = S_INS;
			end
			S_DEL: begin
				if (rd_s1) begin
					we = 1'b1;
					waddr = AW'(ridx_s1 - 1'b1);
					wdata = rdata;
				end
				if (idx_q < stop_q) begin
					idx_d = idx_q + 1'b1;
				end else if (!rd_s1 || ridx_s1 == stop_q - 1'b1) begin
					if (!rd_s1) begin
						count_d = count_q - 1'b1;
						od_d = '{status: ST_OK, element: '0, length: 5'(count_q - 1'b1),
							last: 1'b1};
						ov_d = 1'b1;
						state_d = S_IDLE;
					end
				end
			end
			S_READ: begin
				if (rd_s1 && out_free) begin
					od_d = '{status: ST_OK, element: rdata, length: 5'(count_q),
						last: (ridx_s1 + 1'b1 == stop_q)};
					ov_d = 1'b1;
					if (ridx_s1 + 1'b1 == stop_q) state_d = S_IDLE;
				end
				// element read but output busy: read it again
				if (rd_s1 && !out_free) idx_d = ridx_s1;
				else if (idx_q < stop_q) idx_d = idx_q + 1'b1;
			end
			default: state_d = S_IDLE;
		endcase
	end

endmodule

// File: rtl/core/ple_mem.sv
// ----------------------------------------------------------------------------
// ple_mem
// element store, one write and one read port, registered read data
// ----------------------------------------------------------------------------
module ple_mem import ple_pkg::*; #(
	parameter int CAPACITY = CAPACITY_DEF,
	localparam int AW = $clog2(CAPACITY)
) (
	input  logic          clk,
	input  logic          we,
	input  logic [AW-1:0] waddr,
	input  logic [31:0]   wdata,
	input  logic [AW-1:0] raddr,
	output logic [31:0]   rdata
);

	logic [31:0] mem [CAPACITY];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

// File: rtl/core/ple_checker.sv
// ----------------------------------------------------------------------------
// ple_checker
// port level checks for the positional list engine
// ----------------------------------------------------------------------------
module ple_checker import ple_pkg::*; (
	input logic      clk,
	input logic      arst_n,
	input logic      in_valid,
	input logic      in_stall,
	input in_beat_t  in_data,
	input logic      out_valid,
	input logic      out_stall,
	input out_beat_t out_data
);

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(out_data))
		else $error("stalled output beat changed");

	a_len_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> out_data.length <= 5'd16)
		else $error("length beyond capacity");

	a_elem_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_data.status != ST_OK |-> out_data.element == '0 && out_data.last)
		else $error("status beat malformed");

	a_busy: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_data.last |-> in_stall)
		else $error("input taken mid read-out");

endmodule

bind positional_list_engine_top ple_checker u_ple_checker (.*);
